[design/pid_pkg.sv]
`timescale 1ns / 1ps

package pid_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 30;
  localparam int GAIN_W = 15;
  localparam int SUM_LIM_W = 30;
  localparam int DATA_W = 16;
  localparam int ERR_W = 17;
  localparam int SUM_W = 31;
  localparam int PTERM_W = 32;
  localparam int ITERM_W = 46;
  localparam int ACC_W = 48;
  localparam int QUOT_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SUM_ERROR = 3'd4;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]    p_gain;
    logic [GAIN_W-1:0]    i_gain;
    logic [GAIN_W-1:0]    d_gain;
    logic [GAIN_W-1:0]    max_error;
    logic [SUM_LIM_W-1:0] max_sum_error;
  } pid_cfg_t;

  // Per-stage load enables of the pipeline, front to back.
  typedef struct packed {
    logic front;
    logic terms;
    logic sum;
    logic quot;
    logic drive;
  } pid_load_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } pid_clip_t;

endpackage

[design/pid_cfg.sv]
`timescale 1ns / 1ps

module pid_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pid_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]      wr_data,
  output pid_pkg::pid_cfg_t                   cfg
);

  pid_pkg::pid_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.p_gain        <= '0;
      regs.i_gain        <= '0;
      regs.d_gain        <= '0;
      regs.max_error     <= '1;
      regs.max_sum_error <= '1;
    end else if (wr_en) begin
      case (wr_index)
        pid_pkg::REG_P_GAIN:        regs.p_gain        <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_I_GAIN:        regs.i_gain        <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_D_GAIN:        regs.d_gain        <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_MAX_ERROR:     regs.max_error     <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_MAX_SUM_ERROR: regs.max_sum_error <= wr_data[pid_pkg::SUM_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[design/pid_front.sv]
`timescale 1ns / 1ps

module pid_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  logic                                  clear,
  input  logic                                  load,
  input  pid_pkg::pid_cfg_t                     cfg,
  input  logic signed [pid_pkg::DATA_W-1:0]     set_point,
  input  logic signed [pid_pkg::DATA_W-1:0]     measured_value,
  output logic signed [pid_pkg::ERR_W-1:0]      err,
  output logic signed [pid_pkg::SUM_W-1:0]      sum,
  output pid_pkg::pid_clip_t                    clip,
  output logic [pid_pkg::DATA_W-1:0]            dmeas
);

  logic signed [pid_pkg::SUM_W-1:0]   integral;
  logic signed [pid_pkg::DATA_W-1:0]  prev_meas;
  logic signed [pid_pkg::ERR_W-1:0]   err_now;
  logic signed [pid_pkg::SUM_W:0]     sum_try;
  logic signed [pid_pkg::SUM_W:0]     lim;
  logic                               sum_hi;
  logic                               sum_lo;
  logic signed [pid_pkg::SUM_W-1:0]   sum_next;
  logic [pid_pkg::DATA_W-1:0]         dmeas_now;

  assign err_now = pid_pkg::ERR_W'(set_point) - pid_pkg::ERR_W'(measured_value);
  assign sum_try = (pid_pkg::SUM_W + 1)'(integral) + (pid_pkg::SUM_W + 1)'(err_now);
  assign lim     = $signed({2'b00, cfg.max_sum_error});
  assign sum_hi  = sum_try > lim;
  assign sum_lo  = sum_try < -lim;

  // The clamp acts on the new sum, so a lowered limit pulls the stored sum back.
  always_comb begin
    if (sum_hi) begin
      sum_next = lim[pid_pkg::SUM_W-1:0];
    end else if (sum_lo) begin
      sum_next = -lim[pid_pkg::SUM_W-1:0];
    end else begin
      sum_next = sum_try[pid_pkg::SUM_W-1:0];
    end
  end

  // Only the low sixteen bits of the measurement change reach the D term.
  assign dmeas_now = prev_meas - measured_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral  <= '0;
      prev_meas <= '0;
    end else if (clear) begin
      integral <= '0;
    end else if (take) begin
      integral  <= sum_next;
      prev_meas <= measured_value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err     <= err_now;
      sum     <= sum_next;
      clip.hi <= sum_hi;
      clip.lo <= sum_lo;
      dmeas   <= dmeas_now;
    end
  end

endmodule

[design/pid_terms.sv]
`timescale 1ns / 1ps

module pid_terms #(
  parameter int OUTPUT_LIMIT        = 32767,
  parameter int INTEGRAL_TERM_LIMIT = 1073741823
) (
  input  logic                                  clk,
  input  logic                                  load,
  input  pid_pkg::pid_cfg_t                     cfg,
  input  logic signed [pid_pkg::ERR_W-1:0]      err,
  input  logic signed [pid_pkg::SUM_W-1:0]      sum,
  input  pid_pkg::pid_clip_t                    clip,
  input  logic [pid_pkg::DATA_W-1:0]            dmeas,
  output logic signed [pid_pkg::PTERM_W-1:0]    pterm,
  output logic signed [pid_pkg::ITERM_W-1:0]    iterm,
  output logic signed [pid_pkg::DATA_W-1:0]     dterm
);

  localparam logic signed [pid_pkg::PTERM_W-1:0] P_POS = pid_pkg::PTERM_W'(OUTPUT_LIMIT);
  localparam logic signed [pid_pkg::PTERM_W-1:0] P_NEG = -P_POS;
  localparam logic signed [pid_pkg::ITERM_W-1:0] I_POS = pid_pkg::ITERM_W'(INTEGRAL_TERM_LIMIT);
  localparam logic signed [pid_pkg::ITERM_W-1:0] I_NEG = -I_POS;

  logic signed [pid_pkg::ERR_W-1:0]    lim_e;
  logic                                err_hi;
  logic                                err_lo;
  logic signed [pid_pkg::PTERM_W-1:0]  p_prod;
  logic signed [pid_pkg::ITERM_W-1:0]  i_prod;
  logic [pid_pkg::DATA_W-1:0]          d_low;
  logic signed [pid_pkg::PTERM_W-1:0]  pterm_next;
  logic signed [pid_pkg::ITERM_W-1:0]  iterm_next;

  assign lim_e  = $signed({2'b00, cfg.max_error});
  assign err_hi = err > lim_e;
  assign err_lo = err < -lim_e;

  assign p_prod = $signed({1'b0, cfg.p_gain}) * err;
  assign i_prod = $signed({1'b0, cfg.i_gain}) * sum;
  // The product is taken at sixteen bits, which is the wrap of the D term.
  assign d_low  = pid_pkg::DATA_W'({1'b0, cfg.d_gain} * dmeas);

  always_comb begin
    if (err_hi) begin
      pterm_next = P_POS;
    end else if (err_lo) begin
      pterm_next = P_NEG;
    end else begin
      pterm_next = p_prod;
    end
  end

  always_comb begin
    if (clip.hi) begin
      iterm_next = I_POS;
    end else if (clip.lo) begin
      iterm_next = I_NEG;
    end else begin
      iterm_next = i_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pterm <= pterm_next;
      iterm <= iterm_next;
      dterm <= $signed(d_low);
    end
  end

endmodule

[design/pid_scale.sv]
`timescale 1ns / 1ps

module pid_scale #(
  parameter int SCALING_DIVISOR = 128,
  parameter int OUTPUT_LIMIT    = 32767
) (
  input  logic                                  clk,
  input  pid_pkg::pid_load_t                    load,
  input  logic signed [pid_pkg::PTERM_W-1:0]    pterm,
  input  logic signed [pid_pkg::ITERM_W-1:0]    iterm,
  input  logic signed [pid_pkg::DATA_W-1:0]     dterm,
  output logic signed [pid_pkg::DATA_W-1:0]     drive_value
);

  // Any magnitude at or above the threshold saturates, so only magnitudes
  // below it are divided. The reciprocal is rounded up with enough fraction
  // bits that the truncated product equals the exact quotient.
  localparam longint unsigned SAT_THR =
    longint'(OUTPUT_LIMIT + 1) * longint'(SCALING_DIVISOR);
  localparam int MAG_W   = $clog2(SAT_THR);
  localparam int DIV_LOG = $clog2(SCALING_DIVISOR);
  localparam int SHIFT   = MAG_W + DIV_LOG;
  localparam int RECIP_W = MAG_W + 2;
  localparam int PROD_W  = SHIFT + pid_pkg::DATA_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(SCALING_DIVISOR) - 64'd1) / SCALING_DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [pid_pkg::ACC_W-1:0] SAT_C = pid_pkg::ACC_W'(SAT_THR);
  localparam logic signed [pid_pkg::DATA_W-1:0] LIM_POS = pid_pkg::DATA_W'(OUTPUT_LIMIT);

  logic signed [pid_pkg::ACC_W-1:0]  acc;
  logic [pid_pkg::ACC_W-1:0]         mag_full;
  logic                              acc_neg;

  logic                              neg_a;
  logic                              sat_a;
  logic [MAG_W-1:0]                  mag;

  logic [PROD_W-1:0]                 prod;
  logic                              neg_b;
  logic                              sat_b;
  logic [pid_pkg::QUOT_W-1:0]        quot;

  logic signed [pid_pkg::DATA_W-1:0] quot_s;
  logic signed [pid_pkg::DATA_W-1:0] drive_next;

  assign acc = pid_pkg::ACC_W'(pterm) + pid_pkg::ACC_W'(iterm) + pid_pkg::ACC_W'(dterm);
  assign acc_neg  = acc[pid_pkg::ACC_W-1];
  assign mag_full = acc_neg ? pid_pkg::ACC_W'(-acc) : pid_pkg::ACC_W'(acc);

  always_ff @(posedge clk) begin
    if (load.sum) begin
      neg_a <= acc_neg;
      sat_a <= mag_full >= SAT_C;
      mag   <= mag_full[MAG_W-1:0];
    end
  end

  assign prod = PROD_W'(mag) * PROD_W'(RECIP_C);

  always_ff @(posedge clk) begin
    if (load.quot) begin
      neg_b <= neg_a;
      sat_b <= sat_a;
      quot  <= prod[SHIFT +: pid_pkg::QUOT_W];
    end
  end

  // The quotient is divided as a magnitude, so the sign restored here gives
  // truncation toward zero.
  assign quot_s = $signed({1'b0, quot});

  always_comb begin
    if (sat_b) begin
      drive_next = neg_b ? -LIM_POS : LIM_POS;
    end else begin
      drive_next = neg_b ? -quot_s : quot_s;
    end
  end

  always_ff @(posedge clk) begin
    if (load.drive) begin
      drive_value <= drive_next;
    end
  end

endmodule

[design/pid_controller_step.sv]
`timescale 1ns / 1ps
// Discrete PID controller step with the derivative taken on the measurement.
// A transaction passes through the front, terms, sum, quotient and drive registers before its result is presented.
// Throughput: one transaction per cycle; the five-stage pipeline only holds on output back-pressure.
// A clear transaction takes one input slot and produces no result.
// Reset (synchronous) empties the pipeline, zeroes the gains, integral sum and previous
// measurement, and sets the error and integral-sum limits to their maxima.

module pid_controller_step #(
  parameter int SCALING_DIVISOR     = 128,
  parameter int OUTPUT_LIMIT        = 32767,
  parameter int INTEGRAL_TERM_LIMIT = 1073741823
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic signed [pid_pkg::DATA_W-1:0]     set_point,
  input  logic signed [pid_pkg::DATA_W-1:0]     measured_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pid_pkg::DATA_W-1:0]     drive_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]        cfg_data
);

  pid_pkg::pid_cfg_t                    cfg;
  pid_pkg::pid_load_t                   load;
  pid_pkg::pid_clip_t                   clip;

  logic                                 v_front;
  logic                                 v_terms;
  logic                                 v_sum;
  logic                                 v_quot;
  logic                                 in_fire;
  logic                                 take;
  logic                                 clear;

  logic signed [pid_pkg::ERR_W-1:0]     err;
  logic signed [pid_pkg::SUM_W-1:0]     sum;
  logic [pid_pkg::DATA_W-1:0]           dmeas;
  logic signed [pid_pkg::PTERM_W-1:0]   pterm;
  logic signed [pid_pkg::ITERM_W-1:0]   iterm;
  logic signed [pid_pkg::DATA_W-1:0]    dterm;

  // Nothing is taken while reset is held, since reset would discard it.
  assign cfg_ready = !rst;

  // A stage loads when it is empty or its contents move on this cycle.
  assign load.drive = !out_valid || out_ready;
  assign load.quot  = !v_quot || load.drive;
  assign load.sum   = !v_sum || load.quot;
  assign load.terms = !v_terms || load.sum;
  assign load.front = !v_front || load.terms;

  assign in_ready = load.front && !rst;
  assign in_fire  = in_valid && in_ready;
  assign take     = in_fire && (op == pid_pkg::OP_STEP);
  assign clear    = in_fire && (op == pid_pkg::OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_front   <= 1'b0;
      v_terms   <= 1'b0;
      v_sum     <= 1'b0;
      v_quot    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load.front) begin
        v_front <= take;
      end
      if (load.terms) begin
        v_terms <= v_front;
      end
      if (load.sum) begin
        v_sum <= v_terms;
      end
      if (load.quot) begin
        v_quot <= v_sum;
      end
      if (load.drive) begin
        out_valid <= v_quot;
      end
    end
  end

  pid_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pid_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .clear          (clear),
    .load           (load.front),
    .cfg            (cfg),
    .set_point      (set_point),
    .measured_value (measured_value),
    .err            (err),
    .sum            (sum),
    .clip           (clip),
    .dmeas          (dmeas)
  );

  pid_terms #(
    .OUTPUT_LIMIT        (OUTPUT_LIMIT),
    .INTEGRAL_TERM_LIMIT (INTEGRAL_TERM_LIMIT)
  ) u_terms (
    .clk   (clk),
    .load  (load.terms),
    .cfg   (cfg),
    .err   (err),
    .sum   (sum),
    .clip  (clip),
    .dmeas (dmeas),
    .pterm (pterm),
    .iterm (iterm),
    .dterm (dterm)
  );

  pid_scale #(
    .SCALING_DIVISOR (SCALING_DIVISOR),
    .OUTPUT_LIMIT    (OUTPUT_LIMIT)
  ) u_scale (
    .clk         (clk),
    .load        (load),
    .pterm       (pterm),
    .iterm       (iterm),
    .dterm       (dterm),
    .drive_value (drive_value)
  );

endmodule
